// File: hw/rtl/tsr_pkg.sv
package tsr_pkg;

  localparam int NUM_EXPERTS = 256;
  localparam int TOP_K       = 8;

  localparam int PW     = $clog2(NUM_EXPERTS);
  localparam int KW     = $clog2(TOP_K + 1);
  localparam int IW     = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int SUM_W  = 17 + $clog2(TOP_K);
  localparam int DVD_W  = 33;
  localparam int DCW    = $clog2(DVD_W + 1);
  localparam int FIX_W  = 58;

  localparam logic [15:0]      NEG_ZERO     = 16'h8000;
  localparam logic [15:0]      DIFF_SAT     = 16'd32768;
  localparam logic [32:0]      EXP_ONE      = 33'h1_0000_0000;
  // e^-1 in Q0.32, from the same truncated series with f = 1.0
  localparam logic [32:0]      E_INV        = 33'd1580030169;
  localparam logic [3:0]       SERIES_TERMS = 4'd13;
  localparam logic [7:0]       BIG_EXP      = 8'd167;
  localparam logic [7:0]       POINT_EXP    = 8'd118;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIFF,
    ST_MUL,
    ST_DWAIT,
    ST_POW,
    ST_ACC,
    ST_WGT,
    ST_WWAIT,
    ST_OUT
  } tsr_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } tsr_div_req_t;

  typedef struct packed {
    logic          ins_en;
    logic          clr;
    logic [15:0]   key;
    logic [PW-1:0] idx;
  } tsr_list_cmd_t;

  typedef struct packed {
    logic                    big;
    logic signed [FIX_W-1:0] x;
  } tsr_fix_t;

  function automatic logic [15:0] key_of(input logic [15:0] b);
    return b[15] ? ~b : (b | 16'h8000);
  endfunction

  function automatic logic [15:0] bits_of(input logic [15:0] k);
    return k[15] ? (k & 16'h7fff) : ~k;
  endfunction

  // bfloat16 to Q.16, rounded toward minus infinity, clamped at 2^56
  function automatic tsr_fix_t to_fixed(input logic [15:0] b);
    logic [7:0]  e;
    logic [7:0]  ee;
    logic [7:0]  m;
    logic [6:0]  r;
    logic [56:0] mag;
    logic        lost;
    tsr_fix_t    res;
    e       = b[14:7];
    ee      = (e == 8'd0) ? 8'd1 : e;
    m       = {(e != 8'd0), b[6:0]};
    res.big = 1'b0;
    lost    = 1'b0;
    mag     = '0;
    r       = '0;
    if (e >= BIG_EXP) begin
      res.big = 1'b1;
      mag     = 57'(1) << 56;
    end else if (ee >= POINT_EXP) begin
      mag = 57'(m) << (ee - POINT_EXP);
    end else begin
      r = 7'(POINT_EXP - ee);
      if (r >= 7'd8) begin
        mag  = '0;
        lost = (m != 8'd0);
      end else begin
        mag  = 57'(m >> r[2:0]);
        lost = ((m & ((8'd1 << r[2:0]) - 8'd1)) != 8'd0);
      end
      if (b[15] && lost) mag = mag + 57'd1;
    end
    res.x = b[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return res;
  endfunction

endpackage

// File: hw/rtl/tsr_if.sv
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] logit_bits;
  modport source (output valid, output logit_bits, input ready);
  modport sink   (input valid, input logit_bits, output ready);
endinterface

interface tsr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rank;
  logic [7:0]  expert_index;
  logic [16:0] weight;
  logic        last;
  modport source (output valid, output rank, output expert_index, output weight,
                  output last, input ready);
  modport sink   (input valid, input rank, input expert_index, input weight,
                  input last, output ready);
endinterface

// File: hw/rtl/tsr_div.sv
module tsr_div
  import tsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tsr_div_req_t     req,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DCW-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [SUM_W:0]   trial;
  logic             fits;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCW'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? SUM_W'(trial - {1'b0, dvs_r}) : trial[SUM_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - DCW'(1);
      if (cnt_r == DCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/tsr_list.sv
module tsr_list
  import tsr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tsr_list_cmd_t cmd,
  output logic [15:0]   keys [TOP_K],
  output logic [PW-1:0] idxs [TOP_K],
  output logic [KW-1:0] fill
);

  logic [15:0]   keys_r [TOP_K];
  logic [15:0]   keys_nxt [TOP_K];
  logic [PW-1:0] idxs_r [TOP_K];
  logic [PW-1:0] idxs_nxt [TOP_K];
  logic [KW-1:0] fill_r, fill_nxt;
  logic [TOP_K-1:0] keep;

  // entries that stay ahead of the new key form a prefix of the list
  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      keep[i] = (KW'(i) < fill_r) && (keys_r[i] >= cmd.key);
    end
    for (int i = 0; i < TOP_K; i++) begin
      keys_nxt[i] = keys_r[i];
      idxs_nxt[i] = idxs_r[i];
      if (cmd.ins_en && !keep[i]) begin
        if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
          keys_nxt[i] = cmd.key;
          idxs_nxt[i] = cmd.idx;
        end else begin
          keys_nxt[i] = keys_r[(i == 0) ? 0 : i - 1];
          idxs_nxt[i] = idxs_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
    fill_nxt = fill_r;
    if (cmd.clr) begin
      fill_nxt = '0;
    end else if (cmd.ins_en && fill_r < KW'(TOP_K)) begin
      fill_nxt = fill_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
    keys_r <= keys_nxt;
    idxs_r <= idxs_nxt;
  end

  assign keys = keys_r;
  assign idxs = idxs_r;
  assign fill = fill_r;

endmodule

// File: hw/rtl/topk_softmax_router.sv
// Top-8 softmax router over a run of 256 bfloat16 logits.
// in_ch: one logit per transaction, experts in order. in_ch.ready is high
//   while the block streams a run, one transaction per cycle.
// out_ch: after the last logit of a run, eight results in rank order, each
//   with the expert index, a Q1.16 weight and last on the eighth.
// Tail: the work after the last logit is serial through one shared
//   restoring divider. Each selected entry takes conversion and difference,
//   13 series terms, loading and leaving the power loop plus one multiply
//   per whole unit of the difference (0..32), and an accumulate step. Each
//   weight then takes one divide plus the output transaction. During the
//   whole tail in_ch.ready is low.
// Stall: a result holds on out_ch until taken; the tail waits meanwhile.
// Reset: synchronous, clears the list fill and the expert position; the
//   block comes out of reset ready for the first logit of a run.
module topk_softmax_router
  import tsr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  tsr_in_if.sink    in_ch,
  tsr_out_if.source out_ch
);

  tsr_state_t state_r, state_nxt;

  logic [PW-1:0]           pos_r, pos_nxt;
  logic [KW-1:0]           i_r, i_nxt;
  logic [IW-1:0]           iv;
  logic [3:0]              k_r, k_nxt;
  logic [5:0]              n_r, n_nxt;
  logic [9:0]              f_r, f_nxt;
  logic [32:0]             term_r, term_nxt;
  logic signed [34:0]      acc_r, acc_nxt;
  logic [32:0]             r_r, r_nxt;
  logic signed [FIX_W-1:0] x0_r, x0_nxt, xi_r, xi_nxt;
  logic                    big0_r, big0_nxt, bigi_r, bigi_nxt;
  logic [16:0]             terms_r [TOP_K];
  logic [16:0]             term_wr;
  logic                    term_we;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [2:0]              rank_r, rank_nxt;
  logic [7:0]              eidx_r, eidx_nxt;
  logic [16:0]             wgt_r, wgt_nxt;
  logic                    last_r, last_nxt;

  logic [15:0]   keys [TOP_K];
  logic [PW-1:0] idxs [TOP_K];
  logic [KW-1:0] fill;
  tsr_list_cmd_t list_cmd;
  tsr_div_req_t  div_req;
  logic          div_done;
  logic [DVD_W-1:0] div_q;

  logic [15:0]      in_bits;
  logic             in_txn;
  logic             last_entry;
  tsr_fix_t         fx;
  logic [FIX_W-1:0] nd;
  logic [58:0]      qd;
  logic [42:0]      sprod;
  logic [63:0]      pprod;
  logic [33:0]      rnd;

  tsr_list u_list (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (list_cmd),
    .keys (keys),
    .idxs (idxs),
    .fill (fill)
  );

  tsr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_q)
  );

  assign iv         = i_r[IW-1:0];
  assign in_txn     = in_ch.valid && in_ch.ready;
  assign in_bits    = (in_ch.logit_bits == NEG_ZERO) ? 16'h0000 : in_ch.logit_bits;
  assign last_entry = (KW'(i_r + KW'(1)) == fill);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = (state_r == ST_OUT);
  assign out_ch.rank         = rank_r;
  assign out_ch.expert_index = eidx_r;
  assign out_ch.weight       = wgt_r;
  assign out_ch.last         = last_r;

  always_comb begin
    fx    = to_fixed(bits_of(keys[iv]));
    nd    = FIX_W'(x0_r - xi_r);
    qd    = ({1'b0, nd} + 59'd63) >> 6;
    sprod = 43'(term_r) * 43'(f_r);
    pprod = 64'(r_r) * 64'(E_INV);
    rnd   = {1'b0, r_r} + 34'd32768;

    state_nxt = state_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    f_nxt     = f_r;
    term_nxt  = term_r;
    acc_nxt   = acc_r;
    r_nxt     = r_r;
    x0_nxt    = x0_r;
    xi_nxt    = xi_r;
    big0_nxt  = big0_r;
    bigi_nxt  = bigi_r;
    sum_nxt   = sum_r;
    rank_nxt  = rank_r;
    eidx_nxt  = eidx_r;
    wgt_nxt   = wgt_r;
    last_nxt  = last_r;
    term_wr   = rnd[32:16];
    term_we   = 1'b0;

    list_cmd.ins_en = in_txn;
    list_cmd.clr    = 1'b0;
    list_cmd.key    = key_of(in_bits);
    list_cmd.idx    = pos_r;

    div_req.start    = 1'b0;
    div_req.dividend = sprod[42:10];
    div_req.divisor  = SUM_W'(k_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_txn) begin
          if (pos_r == PW'(NUM_EXPERTS - 1)) begin
            pos_nxt   = '0;
            i_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = ST_CONV;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      ST_CONV: begin
        xi_nxt   = fx.x;
        bigi_nxt = fx.big;
        if (i_r == '0) begin
          x0_nxt   = fx.x;
          big0_nxt = fx.big;
        end
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        // difference to the top entry in Q6.10, rounded toward plus infinity
        if (big0_r && bigi_r && keys[0] != keys[iv]) begin
          f_nxt = DIFF_SAT[9:0];
          n_nxt = DIFF_SAT[15:10];
        end else if (qd > 59'(DIFF_SAT)) begin
          f_nxt = DIFF_SAT[9:0];
          n_nxt = DIFF_SAT[15:10];
        end else begin
          f_nxt = qd[9:0];
          n_nxt = qd[15:10];
        end
        term_nxt  = EXP_ONE;
        acc_nxt   = 35'(EXP_ONE);
        k_nxt     = 4'd1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          term_nxt = div_q;
          acc_nxt  = k_r[0] ? acc_r - $signed({2'b00, div_q})
                            : acc_r + $signed({2'b00, div_q});
          if (k_r == SERIES_TERMS) begin
            state_nxt = ST_POW;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_POW: begin
        if (n_r == 6'd0) begin
          state_nxt = ST_ACC;
        end
        if (n_r != 6'd0) begin
          r_nxt = {1'b0, pprod[63:32]};
          n_nxt = n_r - 6'd1;
        end
        // first pass through loads the series result
        if (k_r == SERIES_TERMS) begin
          k_nxt = '0;
          r_nxt = acc_r[32:0];
          n_nxt = n_r;
          state_nxt = ST_POW;
        end
      end
      ST_ACC: begin
        term_we = 1'b1;
        sum_nxt = sum_r + SUM_W'(rnd[32:16]);
        if (last_entry) begin
          i_nxt     = '0;
          state_nxt = ST_WGT;
        end else begin
          i_nxt     = i_r + KW'(1);
          state_nxt = ST_CONV;
        end
      end
      ST_WGT: begin
        div_req.start    = 1'b1;
        div_req.dividend = {terms_r[iv], 16'h0000} + DVD_W'(sum_r >> 1);
        div_req.divisor  = sum_r;
        state_nxt        = ST_WWAIT;
      end
      ST_WWAIT: begin
        if (div_done) begin
          rank_nxt  = 3'(i_r);
          eidx_nxt  = 8'(idxs[iv]);
          wgt_nxt   = div_q[16:0];
          last_nxt  = last_entry;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          if (last_entry) begin
            list_cmd.clr = 1'b1;
            i_nxt        = '0;
            state_nxt    = ST_IDLE;
          end else begin
            i_nxt     = i_r + KW'(1);
            state_nxt = ST_WGT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
    end
    f_r    <= f_nxt;
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    r_r    <= r_nxt;
    x0_r   <= x0_nxt;
    xi_r   <= xi_nxt;
    big0_r <= big0_nxt;
    bigi_r <= bigi_nxt;
    sum_r  <= sum_nxt;
    rank_r <= rank_nxt;
    eidx_r <= eidx_nxt;
    wgt_r  <= wgt_nxt;
    last_r <= last_nxt;
    if (term_we) terms_r[iv] <= term_wr;
  end

endmodule

// File: hw/rtl/tsr_checker.sv
module tsr_checker
  import tsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_rank,
  input logic [16:0] out_weight,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_rank) && $stable(out_weight))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after last result");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_weight <= 17'd65536)
    else $error("weight above one");

endmodule

bind topk_softmax_router tsr_checker u_tsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rank  (out_ch.rank),
  .out_weight(out_ch.weight),
  .out_last  (out_ch.last)
);
